// File: rtl/assert_macros.svh
// Assertion macros included by haversine_distance_unit.sv, the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/hdu_pkg.sv
// Types, constants and the arctangent table of the haversine distance unit.
package hdu_pkg;

  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 22;

  // half angles in degrees * 131072
  localparam int ANG_W = 27;
  localparam logic signed [ANG_W:0] FULL_TURN    = (ANG_W+1)'(47185920);
  localparam logic signed [ANG_W:0] HALF_TURN    = (ANG_W+1)'(23592960);
  localparam logic signed [ANG_W:0] QUARTER_TURN = (ANG_W+1)'(11796480);

  localparam int MAG_W     = 24;
  localparam int RAD_SPLIT = 20;
  localparam logic [39:0] TO_RAD_Q32 = 40'd614083138246;
  localparam logic [RAD_SPLIT-1:0] TO_RAD_LO = TO_RAD_Q32[RAD_SPLIT-1:0];
  localparam logic [RAD_SPLIT-1:0] TO_RAD_HI = TO_RAD_Q32[39:RAD_SPLIT];
  localparam int ZM_W = 31;

  localparam int Q_FRAC       = 30;
  localparam int Q_W          = 32;
  localparam int XW           = 34;
  localparam int ZW           = 33;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

  localparam int M_W = 33;
  localparam int A_W = 31;
  localparam logic [A_W-1:0] ONE_Q30 = A_W'(1) << Q_FRAC;

  localparam int SQ_NW     = 62;
  localparam int SQ_W      = 31;
  localparam int ISQ_STEPS = 31;

  localparam logic [31:0] MILES_SCALE = 32'd4151055106;
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(3200000);

  localparam int SC_LAT   = 5 + CORDIC_STEPS;
  localparam int PIPE_LAT = 1 + SC_LAT + 4 + ISQ_STEPS + CORDIC_STEPS + 2;

  typedef logic signed [Q_W-1:0] q30_t;

  localparam int ATAN_TAB_N = 16;
  localparam logic [ZW-1:0] ATAN_TAB [ATAN_TAB_N] = '{
    33'd843314856, 33'd497837829, 33'd263043836, 33'd133525158,
    33'd67021686,  33'd33543515,  33'd16775850,  33'd8388437,
    33'd4194282,   33'd2097149,   33'd1048575,   33'd524287,
    33'd262143,    33'd131071,    33'd65535,     33'd32767
  };

  // atan(2^-i) in Q30; past the table it is 2^(30-i) - 1
  function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
    logic signed [ZW-1:0] step;
    if (i < ATAN_TAB_N) begin
      step = $signed(ATAN_TAB[i[3:0]]);
    end else begin
      step = $signed((ZW'(1) << (CORDIC_STEPS - i)) - ZW'(1));
    end
    return step;
  endfunction

endpackage

// File: rtl/hdu_sincos.sv
// Sine pipeline: angle reduction, radian scaling and a rotation CORDIC.
module hdu_sincos (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [hdu_pkg::ANG_W-1:0]   ang_i,
  output hdu_pkg::q30_t                      sin_o
);
  localparam int AW  = hdu_pkg::ANG_W;
  localparam int MW  = hdu_pkg::MAG_W;
  localparam int RS  = hdu_pkg::RAD_SPLIT;
  localparam int PW  = hdu_pkg::MAG_W + hdu_pkg::RAD_SPLIT;
  localparam int ZMW = hdu_pkg::ZM_W;
  localparam int XW  = hdu_pkg::XW;
  localparam int ZW  = hdu_pkg::ZW;
  localparam int NS  = hdu_pkg::CORDIC_STEPS;
  localparam int QW  = hdu_pkg::Q_W;

  logic signed [AW:0] ang_ext, wrap, red_d, red_q;
  logic signed [AW:0] fold, mag_full;
  logic [MW-1:0]      mag_d, mag_q;
  logic               neg_q, neg3_q, neg4_q;
  logic [PW-1:0]      p_hi_q, p_lo_q;
  logic [63:0]        rad_sum;
  logic [ZMW-1:0]     zm_q;

  logic signed [XW-1:0] x_q [NS+1];
  logic signed [XW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];

  // wrap into [-180, 180)
  assign ang_ext = {ang_i[AW-1], ang_i};
  assign wrap    = ang_ext[AW] ? ang_ext + hdu_pkg::FULL_TURN : ang_ext;
  assign red_d   = (wrap >= hdu_pkg::HALF_TURN) ? wrap - hdu_pkg::FULL_TURN : wrap;

  // fold into [-90, 90]
  always_comb begin
    if (red_q > hdu_pkg::QUARTER_TURN) begin
      fold = hdu_pkg::HALF_TURN - red_q;
    end else if (red_q < -hdu_pkg::QUARTER_TURN) begin
      fold = -hdu_pkg::HALF_TURN - red_q;
    end else begin
      fold = red_q;
    end
  end
  assign mag_full = fold[AW] ? -fold : fold;
  assign mag_d    = mag_full[MW-1:0];

  assign rad_sum = {p_hi_q, {RS{1'b0}}} + 64'(p_lo_q) + 64'h8000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q  <= red_d;
      mag_q  <= mag_d;
      neg_q  <= fold[AW];
      p_hi_q <= PW'(mag_q) * PW'(hdu_pkg::TO_RAD_HI);
      p_lo_q <= PW'(mag_q) * PW'(hdu_pkg::TO_RAD_LO);
      neg3_q <= neg_q;
      zm_q   <= rad_sum[32 +: ZMW];
      neg4_q <= neg3_q;
      z_q[0] <= neg4_q ? -$signed({2'b00, zm_q}) : $signed({2'b00, zm_q});
      x_q[0] <= hdu_pkg::CORDIC_GAIN;
      y_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - hdu_pkg::atan_step(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + hdu_pkg::atan_step(i);
        end
      end
    end
  end

  assign sin_o = y_q[NS][QW-1:0];

endmodule

// File: rtl/hdu_isqrt.sv
// Pipelined integer square root of a Q30 value, one result bit per stage.
module hdu_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hdu_pkg::A_W-1:0]      a_i,
  output logic [hdu_pkg::SQ_W-1:0]     root_o
);
  localparam int NW = hdu_pkg::SQ_NW;
  localparam int NS = hdu_pkg::ISQ_STEPS;
  localparam int QF = hdu_pkg::Q_FRAC;

  logic [NW-1:0] n0;
  logic [NW-1:0] n_q [NS];
  logic [NW-1:0] r_q [NS];

  assign n0 = NW'({a_i, {QF{1'b0}}});

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (NS - 1 - i));
    logic [NW-1:0] n_in, r_in, trial;
    if (i == 0) begin : g_first
      assign n_in = n0;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= trial) begin
          n_q[i] <= n_in - trial;
          r_q[i] <= (r_in >> 1) + BIT;
        end else begin
          n_q[i] <= n_in;
          r_q[i] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[NS-1][hdu_pkg::SQ_W-1:0];

endmodule

// File: rtl/haversine_distance_unit.sv
// Throughput: one point pair per cycle while the output queue has room, set by the
// fully pipelined 30-step CORDIC rotators, the 31-step square roots and the 30-step
// vectoring CORDIC.
// A two-entry output queue keeps input transfers flowing while one result waits.
// Reset clears the valid bits and the queue count; datapath registers are not reset.
`include "assert_macros.svh"
module haversine_distance_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [hdu_pkg::LAT_W-1:0]     first_latitude_i,
  input  logic signed [hdu_pkg::LON_W-1:0]     first_longitude_i,
  input  logic signed [hdu_pkg::LAT_W-1:0]     second_latitude_i,
  input  logic signed [hdu_pkg::LON_W-1:0]     second_longitude_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [hdu_pkg::DIST_W-1:0]           distance_miles_o
);
  localparam int AW   = hdu_pkg::ANG_W;
  localparam int QF   = hdu_pkg::Q_FRAC;
  localparam int QW   = hdu_pkg::Q_W;
  localparam int MW   = hdu_pkg::M_W;
  localparam int AAW  = hdu_pkg::A_W;
  localparam int SW   = hdu_pkg::SQ_W;
  localparam int XW   = hdu_pkg::XW;
  localparam int ZW   = hdu_pkg::ZW;
  localparam int NS   = hdu_pkg::CORDIC_STEPS;
  localparam int DW   = hdu_pkg::DIST_W;
  localparam int LAST = hdu_pkg::PIPE_LAT - 1;
  localparam logic [1:0] CNT_EMPTY = 2'd0;
  localparam logic [1:0] CNT_FULL  = 2'd2;

  logic                       en, push, pop;
  logic [hdu_pkg::PIPE_LAT-1:0] v_q;
  logic [1:0]                 cnt_d, cnt_q;
  logic [DW-1:0]              e0_d, e0_q, e1_d, e1_q;

  logic signed [hdu_pkg::LAT_W-1:0] lat1_q, lat2_q;
  logic signed [hdu_pkg::LON_W-1:0] lon1_q, lon2_q;
  logic signed [AW-1:0] ang_dlat, ang_dlon, ang_c1, ang_c2;
  hdu_pkg::q30_t        s1, s2, c1, c2;

  logic signed [2*QW-1:0] pr_s1, pr_c, pr_s2;
  logic signed [2*MW-1:0] pr_m4;
  logic signed [MW-1:0]   m1_q, m2_q, m3_q, m1b_q, m4_q;
  logic signed [MW:0]     a_sum;
  logic [AAW-1:0]         a_d, a_q, a2_q, b_q;
  logic [SW-1:0]          sa, sb;

  logic signed [XW-1:0] vx_q [NS];
  logic signed [XW-1:0] vy_q [NS];
  logic signed [ZW-1:0] vz_q [NS];

  logic [ZW-2:0] z_pos;
  logic [63:0]   prod_q, rnd;
  logic [DW-1:0] d_q;

  // the pipeline moves as one while the output queue has room
  assign en         = (cnt_q != CNT_FULL);
  assign in_stall_o = !en;
  assign push       = en && v_q[LAST];
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      cnt_q <= CNT_EMPTY;
    end else begin
      if (en) begin
        v_q <= {v_q[LAST-1:0], in_valid_i};
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat1_q <= first_latitude_i;
      lon1_q <= first_longitude_i;
      lat2_q <= second_latitude_i;
      lon2_q <= second_longitude_i;
    end
  end

  // half-angle units: a difference is already the half angle
  assign ang_dlat = AW'(lat2_q) - AW'(lat1_q);
  assign ang_dlon = AW'(lon2_q) - AW'(lon1_q);
  assign ang_c1   = AW'(lat1_q) + AW'(lat1_q) + AW'(hdu_pkg::QUARTER_TURN);
  assign ang_c2   = AW'(lat2_q) + AW'(lat2_q) + AW'(hdu_pkg::QUARTER_TURN);

  hdu_sincos u_sin_dlat (.clk_i(clk_i), .en_i(en), .ang_i(ang_dlat), .sin_o(s1));
  hdu_sincos u_sin_dlon (.clk_i(clk_i), .en_i(en), .ang_i(ang_dlon), .sin_o(s2));
  hdu_sincos u_cos_lat1 (.clk_i(clk_i), .en_i(en), .ang_i(ang_c1),   .sin_o(c1));
  hdu_sincos u_cos_lat2 (.clk_i(clk_i), .en_i(en), .ang_i(ang_c2),   .sin_o(c2));

  assign pr_s1 = s1 * s1;
  assign pr_c  = c1 * c2;
  assign pr_s2 = s2 * s2;
  assign pr_m4 = m2_q * m3_q;
  assign a_sum = (MW+1)'(m1b_q) + (MW+1)'(m4_q);

  // clamp to [0, 1]
  always_comb begin
    if (a_sum[MW]) begin
      a_d = '0;
    end else if (a_sum > (MW+1)'(hdu_pkg::ONE_Q30)) begin
      a_d = hdu_pkg::ONE_Q30;
    end else begin
      a_d = a_sum[AAW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q  <= pr_s1[QF +: MW];
      m2_q  <= pr_c[QF +: MW];
      m3_q  <= pr_s2[QF +: MW];
      m1b_q <= m1_q;
      m4_q  <= pr_m4[QF +: MW];
      a_q   <= a_d;
      a2_q  <= a_q;
      b_q   <= hdu_pkg::ONE_Q30 - a_q;
    end
  end

  hdu_isqrt u_sqrt_a (.clk_i(clk_i), .en_i(en), .a_i(a2_q), .root_o(sa));
  hdu_isqrt u_sqrt_b (.clk_i(clk_i), .en_i(en), .a_i(b_q),  .root_o(sb));

  for (genvar i = 0; i < NS; i++) begin : g_vec
    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in;
    if (i == 0) begin : g_first
      assign x_in = $signed({{(XW-SW){1'b0}}, sb});
      assign y_in = $signed({{(XW-SW){1'b0}}, sa});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = vx_q[i-1];
      assign y_in = vy_q[i-1];
      assign z_in = vz_q[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (y_in > 0) begin
          vx_q[i] <= x_in + dx;
          vy_q[i] <= y_in - dy;
          vz_q[i] <= z_in + hdu_pkg::atan_step(i);
        end else begin
          vx_q[i] <= x_in - dx;
          vy_q[i] <= y_in + dy;
          vz_q[i] <= z_in - hdu_pkg::atan_step(i);
        end
      end
    end
  end

  assign z_pos = vz_q[NS-1][ZW-1] ? '0 : vz_q[NS-1][ZW-2:0];
  assign rnd   = prod_q + (64'd1 << 40);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 64'(z_pos) * 64'(hdu_pkg::MILES_SCALE);
      if (rnd[63:41] > 23'(hdu_pkg::DIST_MAX)) begin
        d_q <= hdu_pkg::DIST_MAX;
      end else begin
        d_q <= rnd[41 +: DW];
      end
    end
  end

  // output queue: head drives the port, second entry absorbs a stalled transfer
  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    case ({push, pop})
      2'b10: begin
        if (cnt_q == CNT_EMPTY) begin
          e0_d = d_q;
        end else begin
          e1_d = d_q;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        e0_d  = e1_q;
        cnt_d = cnt_q - 2'd1;
      end
      2'b11: begin
        e0_d = d_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign out_valid_o      = (cnt_q != CNT_EMPTY);
  assign distance_miles_o = e0_q;

  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, v_q[0])
  `ASSERT_NEXT(a_full_holds_pipe, clk_i, rst_ni, v_q[LAST] && cnt_q == CNT_FULL, $stable(v_q))
  `ASSERT_NEXT(a_push_shows, clk_i, rst_ni, push && cnt_q == CNT_EMPTY, out_valid_o && distance_miles_o == $past(d_q))
  `ASSERT_HOLDS(a_full_stalls, clk_i, rst_ni, cnt_q == CNT_FULL, in_stall_o && out_valid_o)

endmodule

// File: test/haversine_distance_unit_tb.sv
// Self-checking testbench for the haversine distance unit: directed and random point pairs.
`timescale 1ns / 1ps
module haversine_distance_unit_tb;

  localparam longint ANG_FULL    = 64'sd47185920;
  localparam longint ANG_HALF    = 64'sd23592960;
  localparam longint ANG_QUARTER = 64'sd11796480;
  localparam longint LAT_SPAN    = 64'sd5898240;
  localparam longint LON_SPAN    = 64'sd11796480;
  localparam int     RANDOM_PAIRS = 880;
  localparam int     CYCLE_LIMIT  = 20000;
  localparam int     DRAIN_CYCLES = 150;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [hdu_pkg::LAT_W-1:0] lat1_drv, lat2_drv;
  logic signed [hdu_pkg::LON_W-1:0] lon1_drv, lon2_drv;
  logic out_valid;
  logic out_stall;
  logic [hdu_pkg::DIST_W-1:0] dist_out;

  haversine_distance_unit dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .first_latitude_i   (lat1_drv),
    .first_longitude_i  (lon1_drv),
    .second_latitude_i  (lat2_drv),
    .second_longitude_i (lon2_drv),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .distance_miles_o   (dist_out)
  );

  typedef struct {
    longint lat1;
    longint lon1;
    longint lat2;
    longint lon2;
    bit     fixed_dist;
    int     typed_dist;
  } pair_row_t;

  logic [hdu_pkg::DIST_W-1:0] dist_queue[$];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint arctan_q30(int i);
    longint tab[16] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                        262143, 131071, 65535, 32767};
    if (i < 16) return tab[i];
    return (64'sd1 <<< (30 - i)) - 1;
  endfunction

  function automatic longint sine_q30(longint ang);
    longint r, x, y, z, dx, dy;
    longint unsigned mag;
    r = ((ang % ANG_FULL) + ANG_FULL) % ANG_FULL;
    if (r >= ANG_HALF) r -= ANG_FULL;
    if (r > ANG_QUARTER) r = ANG_HALF - r;
    else if (r < -ANG_QUARTER) r = -ANG_HALF - r;
    mag = (r < 0) ? -r : r;
    z = longint'((mag * 64'd614083138246 + 64'h80000000) >> 32);
    if (r < 0) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    return y;
  endfunction

  function automatic longint q30_product(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [hdu_pkg::DIST_W-1:0] great_circle_miles(longint la1, longint lo1,
                                                                   longint la2, longint lo2);
    longint s1, s2, c1, c2, hav, sa, sb, x, y, z, dx, dy;
    longint unsigned d;
    s1 = sine_q30(la2 - la1);
    s2 = sine_q30(lo2 - lo1);
    c1 = sine_q30(2 * la1 + ANG_QUARTER);
    c2 = sine_q30(2 * la2 + ANG_QUARTER);
    hav = q30_product(s1, s1) + q30_product(q30_product(c1, c2), q30_product(s2, s2));
    if (hav < 0) hav = 0;
    if (hav > (64'sd1 <<< 30)) hav = 64'sd1 <<< 30;
    sa = floor_sqrt(longint'(hav) << 30);
    sb = floor_sqrt(((64'sd1 <<< 30) - hav) << 30);
    x = sb;
    y = sa;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_q30(i);
      end else begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end
    end
    if (z < 0) z = 0;
    d = (longint'(z) * 64'd4151055106 + (64'd1 << 40)) >> 41;
    if (d > 3200000) d = 3200000;
    return d[hdu_pkg::DIST_W-1:0];
  endfunction

  // ---------------- stimulus ----------------
  pair_row_t directed[] = '{
    '{0, 0, 0, 0, 1, 0},
    '{LAT_SPAN, LON_SPAN, LAT_SPAN, LON_SPAN, 1, 0},
    '{-LAT_SPAN, -LON_SPAN, -LAT_SPAN, -LON_SPAN, 1, 0},
    '{0, 0, 0, LON_SPAN, 0, 0},
    '{0, -LON_SPAN, 0, LON_SPAN, 0, 0},
    '{LAT_SPAN, 0, -LAT_SPAN, 0, 0, 0},
    '{-LAT_SPAN, 0, LAT_SPAN, 0, 0, 0},
    '{LAT_SPAN, 0, LAT_SPAN, LON_SPAN, 0, 0},
    '{0, 0, 1, 0, 0, 0},
    '{0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 5898240, 0, 0},
    '{2621440, -4915200, 2752512, -4849664, 0, 0},
    '{-8388608, -16777216, 8388607, 16777215, 0, 0},
    '{8388607, 16777215, -8388608, -16777216, 0, 0},
    '{7000000, 100, -7000000, 200, 0, 0},
    '{-8388608, 0, -8388608, 0, 1, 0},
    '{0, 0, 0, LON_SPAN - 1, 0, 0},
    '{1, -LON_SPAN, -1, LON_SPAN, 0, 0},
    '{3000000, 500000, -3000000, -11296480, 0, 0},
    '{-1, -1, -1, -1, 1, 0}
  };

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN;
  endfunction

  function automatic pair_row_t random_pair();
    pair_row_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.fixed_dist = 0;
    p.typed_dist = 0;
    p.lat1 = rand_lat();
    p.lon1 = rand_lon();
    case (kind)
      0: begin
        // full-width words, out-of-range coordinates included
        p.lat1 = $signed(24'($urandom));
        p.lon1 = $signed(25'($urandom));
        p.lat2 = $signed(24'($urandom));
        p.lon2 = $signed(25'($urandom));
      end
      1, 2: begin
        p.lat2 = p.lat1 + longint'($urandom_range(0, 2000)) - 1000;
        p.lon2 = p.lon1 + longint'($urandom_range(0, 2000)) - 1000;
      end
      3: begin
        p.lat2 = -p.lat1 + longint'($urandom_range(0, 200)) - 100;
        p.lon2 = p.lon1 + ((p.lon1 < 0) ? LON_SPAN : -LON_SPAN);
      end
      default: begin
        p.lat2 = rand_lat();
        p.lon2 = rand_lon();
      end
    endcase
    return p;
  endfunction

  initial begin
    pair_row_t row;
    int burst_left, gap_left, next_idx, total;
    bit want_drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    lat1_drv = '0;
    lon1_drv = '0;
    lat2_drv = '0;
    lon2_drv = '0;
    stim_done = 1'b0;
    total = directed.size() + RANDOM_PAIRS;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = 0;
    gap_left = 0;
    next_idx = 0;
    want_drain = 1'b0;
    while (!stim_done) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        if (row.fixed_dist) begin
          dist_queue.push_back(row.typed_dist[hdu_pkg::DIST_W-1:0]);
        end else begin
          dist_queue.push_back(great_circle_miles(lat1_drv, lon1_drv, lat2_drv, lon2_drv));
        end
      end
      if (!in_valid || !in_stall) begin
        if (next_idx == total) begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end else if (next_idx == directed.size() && !want_drain) begin
          // hold off once until the pipeline is empty
          in_valid <= 1'b0;
          if (dist_queue.size() == 0) want_drain = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          row = (next_idx < directed.size()) ? directed[next_idx] : random_pair();
          next_idx++;
          lat1_drv <= row.lat1[hdu_pkg::LAT_W-1:0];
          lon1_drv <= row.lon1[hdu_pkg::LON_W-1:0];
          lat2_drv <= row.lat2[hdu_pkg::LAT_W-1:0];
          lon2_drv <= row.lon2[hdu_pkg::LON_W-1:0];
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
    while (dist_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver stall pattern: alternate calm, periodic and random stretches
  int stall_phase;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 300) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= (stall_phase % 5) < 2;
        default: out_stall <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    logic [hdu_pkg::DIST_W-1:0] expected_dist;
    if (rst_n && out_valid && !out_stall) begin
      if (dist_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: distance %0d", dist_out);
      end else begin
        expected_dist = dist_queue.pop_front();
        if (dist_out !== expected_dist) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d actual %0d", expected_dist, dist_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hdu_pkg.sv
rtl/hdu_sincos.sv
rtl/hdu_isqrt.sv
rtl/haversine_distance_unit.sv
test/haversine_distance_unit_tb.sv
